FILE: design/gtipm_pkg.sv
// Shared types and constants for the ground-to-image perspective map core.
// Used by gtipm_front, gtipm_div_step and ground_to_image_perspective_map_core.
package gtipm_pkg;

	localparam int COORD_BITS    = 16;
	localparam int FRAC_OUT_BITS = 8;
	localparam int COEF_W        = 32;
	localparam int QUO_W         = 32;
	localparam int PROD_W        = COEF_W + COORD_BITS;
	localparam int NUM_W         = PROD_W + 2;
	localparam int DIVD_W        = NUM_W + FRAC_OUT_BITS;
	localparam int HI_W          = DIVD_W - QUO_W;
	localparam int REM_W         = NUM_W + 1;
	localparam int IN_W          = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W         = 2 * QUO_W;
	localparam int IDX_W         = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_U_X_GAIN = 3'd0;
	localparam logic [IDX_W-1:0] REG_U_Y_GAIN = 3'd1;
	localparam logic [IDX_W-1:0] REG_U_OFFSET = 3'd2;
	localparam logic [IDX_W-1:0] REG_V_Y_GAIN = 3'd3;
	localparam logic [IDX_W-1:0] REG_V_OFFSET = 3'd4;
	localparam logic [IDX_W-1:0] REG_W_Y_GAIN = 3'd5;
	localparam logic [IDX_W-1:0] REG_W_OFFSET = 3'd6;

	localparam logic [COEF_W-1:0] W_Y_GAIN_RST = 32'h0001_0000;

	typedef struct packed {
		logic [COEF_W-1:0] u_x_gain;
		logic [COEF_W-1:0] u_y_gain;
		logic [COEF_W-1:0] u_offset;
		logic [COEF_W-1:0] v_y_gain;
		logic [COEF_W-1:0] v_offset;
		logic [COEF_W-1:0] w_y_gain;
		logic [COEF_W-1:0] w_offset;
	} coef_t;

	// one divider lane: partial remainder, dividend bits still to shift in, quotient so far
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] nlo;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             ovf;
	} lane_t;

	typedef struct packed {
		logic [NUM_W-1:0] ud;
		logic             zero;
		lane_t            u;
		lane_t            v;
	} div_t;

endpackage

FILE: design/gtipm_front.sv
// Front end: products, sums and divider set-up over three pipeline stages.
// Depends on gtipm_pkg.
module gtipm_front import gtipm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [COORD_BITS-1:0] ground_x,
	input  logic [COORD_BITS-1:0] ground_y,
	input  coef_t                 coef,
	output logic                  out_valid,
	output div_t                  out_item
);

	logic                     valid_s1, valid_s2;
	logic signed [PROD_W-1:0] pux_s1, puy_s1, pvy_s1, pwy_s1;
	logic signed [NUM_W-1:0]  nu_s2, nv_s2, dw_s2;
	div_t                     item_s3;
	logic                     valid_s3;

	// stage 1: the four products
	always_ff @(posedge clk) begin
		if (en) begin
			pux_s1 <= $signed(coef.u_x_gain) * $signed(ground_x);
			puy_s1 <= $signed(coef.u_y_gain) * $signed(ground_y);
			pvy_s1 <= $signed(coef.v_y_gain) * $signed(ground_y);
			pwy_s1 <= $signed(coef.w_y_gain) * $signed(ground_y);
		end
	end

	// stage 2: numerators and denominator
	always_ff @(posedge clk) begin
		if (en) begin
			nu_s2 <= NUM_W'(pux_s1) + NUM_W'(puy_s1) + NUM_W'($signed(coef.u_offset));
			nv_s2 <= NUM_W'(pvy_s1) + NUM_W'($signed(coef.v_offset));
			dw_s2 <= NUM_W'(pwy_s1) + NUM_W'($signed(coef.w_offset));
		end
	end

	// stage 3: magnitudes, signs, overflow test and first partial remainder
	logic [NUM_W-1:0]  mag_u, mag_v, mag_d;
	logic [DIVD_W-1:0] dvd_u, dvd_v;
	logic [HI_W-1:0]   hi_u, hi_v;
	div_t              prep;

	always_comb begin
		mag_u = nu_s2[NUM_W-1] ? NUM_W'(-nu_s2) : NUM_W'(nu_s2);
		mag_v = nv_s2[NUM_W-1] ? NUM_W'(-nv_s2) : NUM_W'(nv_s2);
		mag_d = dw_s2[NUM_W-1] ? NUM_W'(-dw_s2) : NUM_W'(dw_s2);
		dvd_u = DIVD_W'(mag_u) << FRAC_OUT_BITS;
		dvd_v = DIVD_W'(mag_v) << FRAC_OUT_BITS;
		hi_u  = dvd_u[DIVD_W-1:QUO_W];
		hi_v  = dvd_v[DIVD_W-1:QUO_W];
		prep.ud    = mag_d;
		prep.zero  = (mag_d == '0);
		prep.u.rem = REM_W'(hi_u);
		prep.u.nlo = dvd_u[QUO_W-1:0];
		prep.u.quo = '0;
		prep.u.neg = nu_s2[NUM_W-1] ^ dw_s2[NUM_W-1];
		prep.u.ovf = (NUM_W'(hi_u) >= mag_d);
		prep.v.rem = REM_W'(hi_v);
		prep.v.nlo = dvd_v[QUO_W-1:0];
		prep.v.quo = '0;
		prep.v.neg = nv_s2[NUM_W-1] ^ dw_s2[NUM_W-1];
		prep.v.ovf = (NUM_W'(hi_v) >= mag_d);
	end

	always_ff @(posedge clk) begin
		if (en) item_s3 <= prep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_item  = item_s3;

endmodule

FILE: design/gtipm_div_step.sv
// One registered restoring-division step for both the u and v lanes.
// Depends on gtipm_pkg.
module gtipm_div_step import gtipm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  div_t in_item,
	output logic out_valid,
	output div_t out_item
);

	div_t nxt;
	logic valid_q;
	div_t item_q;

	function automatic lane_t step_lane(lane_t l, logic [NUM_W-1:0] ud);
		logic [REM_W-1:0] r;
		logic             ge;
		lane_t            o;
		r     = {l.rem[REM_W-2:0], l.nlo[QUO_W-1]};
		ge    = (r >= REM_W'(ud));
		o     = l;
		o.rem = ge ? REM_W'(r - REM_W'(ud)) : r;
		o.nlo = {l.nlo[QUO_W-2:0], 1'b0};
		o.quo = {l.quo[QUO_W-2:0], ge};
		return o;
	endfunction

	// shift in one dividend bit, trial subtract
	always_comb begin
		nxt   = in_item;
		nxt.u = step_lane(in_item.u, in_item.ud);
		nxt.v = step_lane(in_item.v, in_item.ud);
	end

	always_ff @(posedge clk) begin
		if (en) item_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (en) valid_q <= in_valid;
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

FILE: design/ground_to_image_perspective_map_core.sv
// Ground-plane point to image coordinate projection (pitch-only homography).
// Depends on gtipm_pkg, gtipm_front and gtipm_div_step.
//
// Input beats on s_*: s_tdata holds ground_x then ground_y (signed integers).
// Each beat gives exactly one output beat on m_*: m_tdata holds image_u then
// image_v (signed Q24.8, truncated toward zero, saturated) and m_tuser is the
// zero-divisor flag, with both coordinates zero when it is set.
// Coefficients (Q16.16) are written on the cfg_* channel, which is always
// ready; index beyond six is ignored. Write them only while the core is idle.
// The path runs through three front-end stages (products, sums, set-up), one
// stage per quotient bit of the 32-stage restoring divider, and the output
// register. One point is accepted every clock while the pipeline is not held.
// If the receiver holds m_tready low while a result waits, the whole pipeline
// holds, bubbles included, and s_tready falls; input beats are taken again as
// soon as the output register is read or empty.
// Reset clears all valid bits and loads the coefficient reset values
// (w_y_gain one, all others zero).
module ground_to_image_perspective_map_core import gtipm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // ground_x, ground_y
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // image_u, image_v
	output logic              m_tuser,   // zero_divisor
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0] cfg_data
);

	coef_t coef_q;
	logic  en;
	logic  front_valid;
	div_t  front_item;
	logic  [QUO_W:0] stg_valid;
	div_t  stg_item [QUO_W+1];

	// coefficient registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{w_y_gain: W_Y_GAIN_RST, default: '0};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_U_X_GAIN: coef_q.u_x_gain <= cfg_data;
				REG_U_Y_GAIN: coef_q.u_y_gain <= cfg_data;
				REG_U_OFFSET: coef_q.u_offset <= cfg_data;
				REG_V_Y_GAIN: coef_q.v_y_gain <= cfg_data;
				REG_V_OFFSET: coef_q.v_offset <= cfg_data;
				REG_W_Y_GAIN: coef_q.w_y_gain <= cfg_data;
				REG_W_OFFSET: coef_q.w_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless a result is stuck in the output register
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	gtipm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.ground_x  (s_tdata[COORD_BITS-1:0]),
		.ground_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.coef      (coef_q),
		.out_valid (front_valid),
		.out_item  (front_item)
	);

	assign stg_valid[0] = front_valid;
	assign stg_item[0]  = front_item;

	// divider: one quotient bit per stage
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		gtipm_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stg_valid[i]),
			.in_item   (stg_item[i]),
			.out_valid (stg_valid[i+1]),
			.out_item  (stg_item[i+1])
		);
	end

	// saturate, apply sign
	function automatic logic [QUO_W-1:0] finish(lane_t l);
		logic sat;
		sat = l.ovf || (l.neg ? (l.quo > {1'b1, {(QUO_W-1){1'b0}}}) : l.quo[QUO_W-1]);
		if (sat) return l.neg ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
		return l.neg ? QUO_W'(-l.quo) : l.quo;
	endfunction

	div_t             last;
	logic [QUO_W-1:0] res_u, res_v;
	always_comb begin
		last  = stg_item[QUO_W];
		res_u = last.zero ? '0 : finish(last.u);
		res_v = last.zero ? '0 : finish(last.v);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {res_v, res_u};
			m_tuser <= last.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= stg_valid[QUO_W];
	end

`ifndef SYNTHESIS
	a_zero_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero divisor beat with non-zero coordinates");
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stg_valid))
		else $error("divider valid bits moved during a stall");
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output register state");
`endif

endmodule

FILE: dv/ground_to_image_perspective_map_core_tb.sv
// Testbench for ground_to_image_perspective_map_core: projects ground points through
// a locally computed pitch-only homography and compares every output beat.
// Depends on gtipm_pkg and the core RTL.
`timescale 1ns / 100ps

module ground_to_image_perspective_map_core_tb;
	import gtipm_pkg::*;

	typedef struct {
		logic [31:0] u;
		logic [31:0] v;
		logic        zdiv;
	} image_pt_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [COEF_W-1:0] cfg_data;

	// local copy of the coefficient set
	logic signed [31:0] coef [0:6];
	image_pt_t          pending_pts [$];
	int                 n_errors;
	int                 n_points;
	int                 n_zdiv;
	int                 n_sat;
	bit                 calm;

	ground_to_image_perspective_map_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// scaled, truncated, saturated quotient; den is non-zero
	function automatic logic [31:0] scaled_ratio(input longint num, input longint den);
		logic [63:0] mag_n, mag_d, q, r, lim;
		bit neg;
		neg = (num < 0) != (den < 0);
		mag_n = (num < 0) ? -num : num;
		mag_d = (den < 0) ? -den : den;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		q = mag_n / mag_d;
		r = mag_n % mag_d;
		if (q > lim) begin
			q = lim;
		end else begin
			for (int i = 0; i < FRAC_OUT_BITS; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= mag_d) begin
					r = r - mag_d;
					q[0] = 1'b1;
				end
			end
			if (q > lim) q = lim;
		end
		if (q == lim) n_sat++;
		if (neg) q = -q;
		return q[31:0];
	endfunction

	function automatic image_pt_t project_point(input logic signed [15:0] gx,
			input logic signed [15:0] gy);
		image_pt_t p;
		longint x, y, nu, nv, w;
		x = gx;
		y = gy;
		nu = longint'(coef[0]) * x + longint'(coef[1]) * y + longint'(coef[2]);
		nv = longint'(coef[3]) * y + longint'(coef[4]);
		w = longint'(coef[5]) * y + longint'(coef[6]);
		if (w == 0) begin
			p.u = '0;
			p.v = '0;
			p.zdiv = 1'b1;
		end else begin
			p.u = scaled_ratio(nu, w);
			p.v = scaled_ratio(nv, w);
			p.zdiv = 1'b0;
		end
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		n_errors++;
	endtask

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 18);
	endfunction

	// send one ground point, waiting for acceptance; valid stays up for the next beat
	task automatic send_point(input logic [15:0] gx, input logic [15:0] gy);
		cfg_valid <= 1'b0;
		while (idle_now()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {gy, gx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_pts.insert(pending_pts.size(), project_point(gx, gy));
	endtask

	// one register write; valid stays up for a following write
	task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= REG_W_OFFSET) coef[idx] = val;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_pts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic load_coefs(input logic [31:0] c [0:6]);
		write_coef(REG_U_X_GAIN, c[0]);
		write_coef(REG_U_Y_GAIN, c[1]);
		write_coef(REG_U_OFFSET, c[2]);
		write_coef(REG_V_Y_GAIN, c[3]);
		write_coef(REG_V_OFFSET, c[4]);
		write_coef(REG_W_Y_GAIN, c[5]);
		write_coef(REG_W_OFFSET, c[6]);
	endtask

	// receiver: random back-pressure, checks each output beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_pts.size() == 0) begin
					$display("output beat with nothing expected");
					n_errors++;
				end else begin
					image_pt_t e;
					e = pending_pts.pop_front();
					if (m_tdata[31:0] !== e.u) report_mismatch("image_u", m_tdata[31:0], e.u);
					if (m_tdata[63:32] !== e.v)
						report_mismatch("image_v", m_tdata[63:32], e.v);
					if (m_tuser !== e.zdiv) report_mismatch("zero_divisor", m_tuser, e.zdiv);
					n_points++;
					if (e.zdiv) n_zdiv++;
				end
			end
			m_tready <= !idle_now();
		end
	end

	// points at reset coefficients: u and v zero, w equals y
	task automatic test_reset_values();
		send_point(16'h0000, 16'h0000);
		send_point(16'h7FFF, 16'h0001);
		send_point(16'h8000, 16'hFFFF);
		drain();
	endtask

	// field extremes with a typical camera set and with extreme coefficients
	task automatic test_directed();
		logic [31:0] cam [0:6];
		logic [31:0] ext [0:6];
		logic [15:0] edges [0:4];
		cam = '{32'h01F4_0000, 32'h00A0_0000, 32'h0120_0000, 32'hFF80_0000,
			32'h0300_0000, 32'h0000_F000, 32'h0001_8000};
		ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000};
		edges = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
		load_coefs(cam);
		foreach (edges[i]) send_point(edges[i], edges[4 - i]);
		send_point(16'h1234, 16'hFFE7);
		drain();
		load_coefs(ext);
		foreach (edges[i]) send_point(edges[i], edges[i]);
		drain();
		// denominator zero at y = 4: w_y_gain 1.0, w_offset -4.0
		write_coef(REG_W_Y_GAIN, 32'h0001_0000);
		write_coef(REG_W_OFFSET, 32'hFFFC_0000);
		send_point(16'h0055, 16'h0004);
		send_point(16'h0055, 16'h0005);
		drain();
		// out-of-range index is ignored
		write_coef(3'd7, 32'hDEAD_BEEF);
		send_point(16'h8000, 16'h0004);
		drain();
	endtask

	// random coefficient sets, each with a burst of random points
	task automatic test_random(input int sets, input int per_set);
		logic [31:0] c [0:6];
		logic [15:0] gx, gy;
		bit          sgn;
		for (int s = 0; s < sets; s++) begin
			foreach (c[i]) begin
				case ($urandom_range(3))
					0: c[i] = $urandom;
					1: c[i] = $urandom_range(1, 3) == 1 ? 32'h8000_0000 : 32'h7FFF_FFFF;
					default: begin
						sgn = 1'($urandom_range(1));
						c[i] = {{12{sgn}}, 20'($urandom)} ^ 32'($urandom_range(1));
					end
				endcase
			end
			// small denominators often, so zero divisors turn up
			if ($urandom_range(2) == 0) begin
				c[5] = 32'h0001_0000;
				c[6] = {16'($urandom_range(0, 16)) ^ 16'hFFFF, 16'h0} + 32'h0001_0000;
			end
			load_coefs(c);
			calm = (s == 2);
			for (int k = 0; k < per_set; k++) begin
				gx = $urandom;
				gy = ($urandom_range(1)) ? 16'($urandom_range(0, 20)) : 16'($urandom);
				send_point(gx, gy);
			end
			calm = 1'b0;
			drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		n_errors = 0;
		n_points = 0;
		n_zdiv = 0;
		n_sat = 0;
		calm = 1'b0;
		foreach (coef[i]) coef[i] = 0;
		coef[5] = 32'sh0001_0000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_random(10, 40);
		$display("covered %0d points over reset, directed and 10 random coefficient sets,",
			n_points);
		$display("%0d zero divisors, %0d saturating quotients", n_zdiv, n_sat);
		if (n_errors == 0 && pending_pts.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
design/gtipm_pkg.sv
design/gtipm_front.sv
design/gtipm_div_step.sv
design/ground_to_image_perspective_map_core.sv
dv/ground_to_image_perspective_map_core_tb.sv
